[rtl/core/urc_pkg.sv]
// ----------------------------------------------------------------------------
// urc_pkg: shared types and constants for the ultrasonic range controller
// Payload structs, configuration register map and protocol byte codes.
// ----------------------------------------------------------------------------
`default_nettype none

package urc_pkg;

  // Echo counter width (8..16) and the reported count width.
  localparam int unsigned CountBits = 16;
  localparam int unsigned CountOutW = 16;

  // APB register map, index = paddr[2].
  localparam int unsigned AddrW    = 3;
  localparam logic        RegMaxCount    = 1'b0;
  localparam logic        RegTriggerTicks = 1'b1;

  localparam logic [15:0] MaxCountReset     = 16'd1520;
  localparam logic [7:0]  TriggerTicksReset = 8'd1;

  // Command protocol bytes.
  localparam logic [7:0] HdrByte  = 8'hFF;
  localparam logic [7:0] CmdStart = 8'h05;

  typedef logic [CountOutW-1:0] cnt_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       echo;
  } in_item_t;

  typedef struct packed {
    logic       trigger;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] max_count;
    logic [7:0]  trigger_ticks;
  } cfg_t;

  // Per-tick outcome handed from the tick logic to the reply sequencer.
  typedef struct packed {
    logic trig;
    logic send;
    cnt_t count;
  } tick_res_t;

endpackage

`default_nettype wire

[rtl/core/urc_if.sv]
// ----------------------------------------------------------------------------
// urc_if: valid/ready stream interfaces of the range controller
// One interface for the tick items, one for the reply items.
// ----------------------------------------------------------------------------
`default_nettype none

interface urc_in_if;
  logic               valid;
  logic               ready;
  urc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface urc_out_if;
  logic               valid;
  logic               ready;
  urc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/urc_cfg.sv]
// ----------------------------------------------------------------------------
// urc_cfg: APB configuration registers
// Holds max_count and trigger_ticks; zero-wait writes and reads.
// ----------------------------------------------------------------------------
`default_nettype none

module urc_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [urc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output urc_pkg::cfg_t             cfg_o
);

  logic        wr_en;
  logic        idx;
  logic [15:0] max_count_q;
  logic [15:0] max_count_d;
  logic [7:0]  trig_ticks_q;
  logic [7:0]  trig_ticks_d;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[2];

  always_comb begin
    max_count_d  = max_count_q;
    trig_ticks_d = trig_ticks_q;
    if (wr_en) begin
      case (idx)
        urc_pkg::RegMaxCount:     max_count_d  = pwdata[15:0];
        urc_pkg::RegTriggerTicks: trig_ticks_d = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q  <= urc_pkg::MaxCountReset;
      trig_ticks_q <= urc_pkg::TriggerTicksReset;
    end else begin
      max_count_q  <= max_count_d;
      trig_ticks_q <= trig_ticks_d;
    end
  end

  always_comb begin
    case (idx)
      urc_pkg::RegMaxCount:     prdata = {16'd0, max_count_q};
      urc_pkg::RegTriggerTicks: prdata = {24'd0, trig_ticks_q};
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{max_count: max_count_q, trigger_ticks: trig_ticks_q};

endmodule

`default_nettype wire

[rtl/core/urc_tick.sv]
// ----------------------------------------------------------------------------
// urc_tick: per-tick state update
// Echo timing, trigger pulse and command parser, advanced once per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module urc_tick #(
  parameter int unsigned COUNT_BITS = urc_pkg::CountBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  urc_pkg::in_item_t   item_i,
  input  urc_pkg::cfg_t       cfg_i,
  output urc_pkg::tick_res_t  res_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic                  prev_hdr_q, prev_hdr_d;
  logic                  hdr_seen_q, hdr_seen_d;
  logic                  start_req_q, start_req_d;
  logic [7:0]            trig_left_q, trig_left_d;
  logic                  armed_q, armed_d;
  logic                  measuring_q, measuring_d;
  logic [COUNT_BITS-1:0] ticks_q, ticks_d;
  logic [COUNT_BITS-1:0] ticks_inc;
  logic [7:0]            trig_left_tmp;

  always_comb begin
    prev_hdr_d    = prev_hdr_q;
    hdr_seen_d    = hdr_seen_q;
    start_req_d   = start_req_q;
    armed_d       = armed_q;
    measuring_d   = measuring_q;
    ticks_d       = ticks_q;
    res_o         = '0;
    ticks_inc     = (ticks_q == CountMax) ? ticks_q : ticks_q + 1'b1;
    trig_left_tmp = trig_left_q;
    trig_left_d   = trig_left_q;

    // echo phase
    if (measuring_q) begin
      ticks_d = ticks_inc;
      if (!item_i.echo) begin
        measuring_d = 1'b0;
        ticks_d     = '0;
        if (urc_pkg::cnt_t'(ticks_inc) <= cfg_i.max_count) begin
          res_o.send  = 1'b1;
          res_o.count = urc_pkg::cnt_t'(ticks_inc);
        end
      end
    end else if (armed_q && item_i.echo) begin
      armed_d     = 1'b0;
      measuring_d = 1'b1;
      ticks_d     = '0;
    end

    // trigger phase
    if (trig_left_q == 8'd0 && start_req_q) begin
      trig_left_tmp = (cfg_i.trigger_ticks == 8'd0) ? 8'd1 : cfg_i.trigger_ticks;
      start_req_d   = 1'b0;
    end
    trig_left_d = trig_left_tmp;
    if (trig_left_tmp != 8'd0) begin
      res_o.trig  = 1'b1;
      trig_left_d = trig_left_tmp - 8'd1;
      if (trig_left_tmp == 8'd1) begin
        armed_d = 1'b1;
      end
    end

    // command parser
    if (item_i.byte_valid) begin
      if (hdr_seen_q) begin
        if (item_i.rx_byte == urc_pkg::CmdStart) begin
          start_req_d = 1'b1;
        end
        hdr_seen_d = 1'b0;
        prev_hdr_d = 1'b0;
      end else if (item_i.rx_byte == urc_pkg::HdrByte && prev_hdr_q) begin
        hdr_seen_d = 1'b1;
        prev_hdr_d = 1'b0;
      end else begin
        prev_hdr_d = (item_i.rx_byte == urc_pkg::HdrByte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_hdr_q  <= 1'b0;
      hdr_seen_q  <= 1'b0;
      start_req_q <= 1'b0;
      trig_left_q <= 8'd0;
      armed_q     <= 1'b0;
      measuring_q <= 1'b0;
      ticks_q     <= '0;
    end else if (fire_i) begin
      prev_hdr_q  <= prev_hdr_d;
      hdr_seen_q  <= hdr_seen_d;
      start_req_q <= start_req_d;
      trig_left_q <= trig_left_d;
      armed_q     <= armed_d;
      measuring_q <= measuring_d;
      ticks_q     <= ticks_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/urc_reply.sv]
// ----------------------------------------------------------------------------
// urc_reply: result register and reply sequencer
// Emits one plain item per tick, or the four-byte reply frame.
// ----------------------------------------------------------------------------
`default_nettype none

module urc_reply (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  urc_pkg::tick_res_t res_i,
  output logic               free_o,
  urc_out_if.source          out
);

  logic               busy_q, busy_d;
  logic [1:0]         beat_q, beat_d;
  urc_pkg::tick_res_t res_q;
  logic               out_fire;
  logic               last_beat;

  assign last_beat = !res_q.send || (beat_q == 2'd3);
  assign out_fire  = out.valid && out.ready;
  assign free_o    = !busy_q || (out_fire && last_beat);

  assign out.valid         = busy_q;
  assign out.data.trigger  = res_q.trig;
  assign out.data.tx_valid = res_q.send;
  assign out.data.last     = last_beat;

  always_comb begin
    out.data.tx_byte = 8'd0;
    if (res_q.send) begin
      case (beat_q)
        2'd0, 2'd1: out.data.tx_byte = urc_pkg::HdrByte;
        2'd2:       out.data.tx_byte = res_q.count[15:8];
        default:    out.data.tx_byte = res_q.count[7:0];
      endcase
    end
  end

  always_comb begin
    busy_d = busy_q;
    beat_d = beat_q;
    if (load_i) begin
      busy_d = 1'b1;
      beat_d = 2'd0;
    end else if (out_fire) begin
      if (last_beat) begin
        busy_d = 1'b0;
      end else begin
        beat_d = beat_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ultrasonic_range_controller_unit.sv]
// ----------------------------------------------------------------------------
// ultrasonic_range_controller_unit: ultrasonic echo-pulse ranging controller
// Parses FF FF 05 start commands, pulses the trigger, times the echo and
// returns the frame FF FF high low for in-range echoes.
// ----------------------------------------------------------------------------
//
//  port      direction  beat                         results per transfer
//  --------  ---------  ---------------------------  --------------------
//  in_i      sink       byte_valid, rx_byte, echo    -
//  out_o     source     trigger, tx_valid, tx_byte,  1, or 4 with a frame
//                       last
//  apb       slave      max_count, trigger_ticks     -
//
//  An input transfer updates the tick state in the same edge and loads the
//  result register; its first result appears on out_o the next cycle.
//  A tick that sends a frame occupies out_o for four beats, so the next input
//  is taken with the transfer of the frame's last beat.
//  in_i.ready stays high while the result register is empty or its last
//  beat transfers, so a stalled out_o holds input back after one tick.
//  rst_ni clears all control state asynchronously; registers load defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_controller_unit #(
  parameter int unsigned COUNT_BITS = urc_pkg::CountBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  urc_in_if.sink                    in_i,
  urc_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [urc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  urc_pkg::cfg_t      cfg;
  urc_pkg::tick_res_t tick_res;
  logic               reply_free;
  logic               in_fire;

  // Take a new tick whenever the result register can be reloaded.
  assign in_i.ready = reply_free;
  assign in_fire    = in_i.valid && reply_free;

  urc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Echo, trigger and parser state; advance only on an input transfer.
  urc_tick #(
    .COUNT_BITS (COUNT_BITS)
  ) u_tick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .item_i (in_i.data),
    .cfg_i  (cfg),
    .res_o  (tick_res)
  );

  // Hold the tick outcome and drain it as one or four output beats.
  urc_reply u_reply (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (in_fire),
    .res_i  (tick_res),
    .free_o (reply_free),
    .out    (out_o)
  );

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ultrasonic_range_controller_unit
// Drives base ticks (command byte, echo level) through the input stream,
// predicts every reply beat from a local model of the ranging controller
// or a directed row's typed outcome and compares it field by field, with
// random idling on both streams and register writes between test phases.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  // Saturation value of the echo counter at the default counter width.
  localparam urc_pkg::cnt_t CntSat = urc_pkg::cnt_t'((32'd1 << urc_pkg::CountBits) - 1);

  // One directed row: stimulus, and the tick outcome where it is typed in.
  typedef struct packed {
    logic          bv;
    logic [7:0]    rx;
    logic          echo;
    logic          typed;
    logic          trig;
    logic          send;
    urc_pkg::cnt_t count;
  } row_t;

  // Columns: byte_valid, rx_byte, echo, typed, trigger, frame, count.
  localparam row_t DirRows [26] = '{
    '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0},  // quiet tick after reset
    '{1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0},  // echo ignored while not armed
    '{1'b1, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0},  // header complete
    '{1'b1, 8'h05, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0},  // start queued
    '{1'b0, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0},  // one-tick trigger, arm
    '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},  // echo rises
    '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 16'd2},  // echo falls, frame count 2
    '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},  // byte after header, no new header
    '{1'b1, 8'h05, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b1, 8'h04, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},  // wrong command, rearm
    '{1'b0, 8'h05, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},  // byte not valid
    '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b1, 8'h05, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},  // trigger, echo already high
    '{1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},  // measurement starts
    '{1'b1, 8'h05, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},  // request while measuring
    '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},  // arm while measuring
    '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},  // kept arm restarts
    '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0}
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [urc_pkg::AddrW-1:0] paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  urc_in_if  in_if ();
  urc_out_if out_if ();

  ultrasonic_range_controller_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Local copy of the controller state and its registers.
  logic          hdr_prev    = 1'b0;
  logic          hdr_seen    = 1'b0;
  logic          req_pending = 1'b0;
  logic [7:0]    pulse_left  = '0;
  logic          armed       = 1'b0;
  logic          timing      = 1'b0;
  urc_pkg::cnt_t echo_cnt    = '0;
  logic [15:0]   cfg_max_count  = urc_pkg::MaxCountReset;
  logic [7:0]    cfg_trig_ticks = urc_pkg::TriggerTicksReset;

  urc_pkg::out_item_t reply_q [$];   // reply beats still to come, oldest first
  urc_pkg::out_item_t exp_reply;
  int unsigned        err_cnt = 0;
  int unsigned        n_items = 0;
  bit                 no_idle = 1'b0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Advance the controller by one tick: echo timing, then trigger pulse,
  // then the command parser. Return what the tick puts on the reply stream.
  function automatic urc_pkg::tick_res_t ranging_step(urc_pkg::in_item_t it);
    urc_pkg::tick_res_t r;
    r = '0;
    if (timing) begin
      if (echo_cnt != CntSat) echo_cnt = echo_cnt + 1'b1;
      if (!it.echo) begin
        timing = 1'b0;
        if (echo_cnt <= cfg_max_count) begin
          r.send  = 1'b1;
          r.count = echo_cnt;
        end
        echo_cnt = '0;
      end
    end else if (armed && it.echo) begin
      armed    = 1'b0;
      timing   = 1'b1;
      echo_cnt = '0;
    end

    if (pulse_left == 8'd0 && req_pending) begin
      pulse_left  = (cfg_trig_ticks == 8'd0) ? 8'd1 : cfg_trig_ticks;
      req_pending = 1'b0;
    end
    if (pulse_left != 8'd0) begin
      r.trig     = 1'b1;
      pulse_left = pulse_left - 8'd1;
      if (pulse_left == 8'd0) armed = 1'b1;
    end

    if (it.byte_valid) begin
      if (hdr_seen) begin
        if (it.rx_byte == urc_pkg::CmdStart) req_pending = 1'b1;
        hdr_seen = 1'b0;
        hdr_prev = 1'b0;
      end else if (it.rx_byte == urc_pkg::HdrByte && hdr_prev) begin
        hdr_seen = 1'b1;
        hdr_prev = 1'b0;
      end else begin
        hdr_prev = (it.rx_byte == urc_pkg::HdrByte);
      end
    end
    return r;
  endfunction

  // Expand a tick outcome into its reply beats: one idle beat, or a frame.
  function automatic void queue_reply(urc_pkg::tick_res_t r);
    urc_pkg::out_item_t o;
    o.trigger = r.trig;
    if (r.send) begin
      o.tx_valid = 1'b1;
      o.last     = 1'b0;
      o.tx_byte  = urc_pkg::HdrByte;
      reply_q.push_back(o);
      reply_q.push_back(o);
      o.tx_byte  = r.count[15:8];
      reply_q.push_back(o);
      o.tx_byte  = r.count[7:0];
      o.last     = 1'b1;
      reply_q.push_back(o);
    end else begin
      o.tx_valid = 1'b0;
      o.tx_byte  = 8'h00;
      o.last     = 1'b1;
      reply_q.push_back(o);
    end
  endfunction

  function automatic void flag_error(string what, urc_pkg::out_item_t want,
                                     urc_pkg::out_item_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display({"%s: expected trig=%0b valid=%0b byte=%02h last=%0b, ",
                "got trig=%0b valid=%0b byte=%02h last=%0b"},
               what, want.trigger, want.tx_valid, want.tx_byte, want.last,
               got.trigger, got.tx_valid, got.tx_byte, got.last);
  endfunction

  // Bias bytes toward the protocol codes so headers form often.
  function automatic logic [7:0] pick_byte();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 30) return urc_pkg::HdrByte;
    if (p < 45) return urc_pkg::CmdStart;
    return 8'($urandom);
  endfunction

  // Transfer one tick, optionally after a gap; predict at the accepting edge.
  // Leave valid high on return so back-to-back ticks need no second assignment.
  task automatic send_tick(urc_pkg::in_item_t it, logic typed, urc_pkg::tick_res_t want);
    urc_pkg::tick_res_t r;
    if (!no_idle && $urandom_range(99) < 28) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while (!no_idle && $urandom_range(99) < 28);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    r = ranging_step(it);
    queue_reply(typed ? want : r);
    n_items++;
  endtask

  task automatic tick(logic bv, logic [7:0] rx, logic echo);
    urc_pkg::in_item_t it;
    it.byte_valid = bv;
    it.rx_byte    = rx;
    it.echo       = echo;
    send_tick(it, 1'b0, '0);
  endtask

  // APB write: setup cycle, access cycle, then psel low again.
  task automatic write_reg(logic idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == urc_pkg::RegMaxCount) cfg_max_count  = val[15:0];
    else                             cfg_trig_ticks = val[7:0];
    @(posedge clk_i);
  endtask

  // Stop the tick stream, let every pending reply drain, then rewrite both
  // registers while the block is idle.
  task automatic reconfigure(logic [31:0] max_val, logic [31:0] trig_val);
    in_if.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    write_reg(urc_pkg::RegMaxCount, max_val);
    write_reg(urc_pkg::RegTriggerTicks, trig_val);
  endtask

  // FF FF code, with the odd empty tick before or between bytes and echo held low.
  task automatic send_command(logic [7:0] code);
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(3) == 0) tick(1'b0, 8'($urandom), 1'b0);
      tick(1'b1, (k == 2) ? code : urc_pkg::HdrByte, 1'b0);
    end
  endtask

  // One measurement: command, trigger pulse, echo pulse of chosen width.
  // Stray bytes during the pulse may queue a second request.
  task automatic ranging_session();
    int unsigned sel;
    int unsigned hi;
    send_command(($urandom_range(7) == 0) ? pick_byte() : urc_pkg::CmdStart);
    while (req_pending || pulse_left != 8'd0)
      tick(1'($urandom_range(7) == 0), pick_byte(), 1'b0);
    repeat ($urandom_range(2)) tick(1'b0, 8'($urandom), 1'b0);

    sel = $urandom_range(9);
    if (sel < 6) begin
      hi = $urandom_range(1, 20);
    end else if (sel < 8 && cfg_max_count <= 16'd300) begin
      // land on either side of the reporting limit
      hi = int'(cfg_max_count) + $urandom_range(2);
      hi = (hi > 1) ? hi - 1 : 1;
    end else begin
      hi = $urandom_range(21, 120);
    end
    repeat (hi) tick(1'($urandom_range(7) == 0), pick_byte(), 1'b1);
    tick(1'($urandom_range(1)), pick_byte(), 1'b0);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6))
      tick(1'($urandom_range(1)), pick_byte(), 1'($urandom_range(1)));
  endtask

  task automatic random_phase(int unsigned budget);
    int unsigned stop;
    stop = n_items + budget;
    while (n_items < stop) begin
      if ($urandom_range(9) < 7) ranging_session();
      else                       noise_burst();
    end
  endtask

  // Reply sink: check each transfer against the oldest expected beat, then
  // pick ready for the next cycle.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (reply_q.size() == 0) begin
          flag_error("reply with none pending", '0, out_if.data);
        end else begin
          exp_reply = reply_q.pop_front();
          if (out_if.data.trigger  !== exp_reply.trigger  ||
              out_if.data.tx_valid !== exp_reply.tx_valid ||
              out_if.data.tx_byte  !== exp_reply.tx_byte  ||
              out_if.data.last     !== exp_reply.last)
            flag_error("reply mismatch", exp_reply, out_if.data);
        end
      end
      out_if.ready <= no_idle || ($urandom_range(99) >= 28);
    end
  end

  // Main sequence.
  initial begin
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at the reset register values.
    foreach (DirRows[i])
      send_tick({DirRows[i].bv, DirRows[i].rx, DirRows[i].echo}, DirRows[i].typed,
                {DirRows[i].trig, DirRows[i].send, DirRows[i].count});

    // Nothing in range, long trigger pulse.
    reconfigure(32'd0, 32'd12);
    random_phase(30);

    // Widest range, trigger ticks of zero (taken as one); hold a long echo
    // with both streams running flat out.
    reconfigure(32'h0000_FFFF, 32'd0);
    no_idle = 1'b1;
    send_command(urc_pkg::CmdStart);
    while (req_pending || pulse_left != 8'd0) tick(1'b0, 8'h00, 1'b0);
    repeat (40) tick(1'b0, 8'h00, 1'b1);
    tick(1'b0, 8'h00, 1'b0);
    no_idle = 1'b0;
    random_phase(20);

    // Upper data bits must be dropped by the registers.
    reconfigure(32'hABCD_0014, 32'h0000_1203);
    random_phase(40);

    reconfigure($urandom_range(400), $urandom_range(1, 6));
    no_idle = 1'b1;
    random_phase(20);
    no_idle = 1'b0;
    random_phase(30);

    // Drain and let the last beats settle.
    in_if.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

[ultrasonic_range_controller_unit.f]
rtl/core/urc_pkg.sv
rtl/core/urc_if.sv
rtl/core/urc_cfg.sv
rtl/core/urc_tick.sv
rtl/core/urc_reply.sv
rtl/core/ultrasonic_range_controller_unit.sv
sim/testbench.sv
